// ===== hdl/wdie_pkg.sv =====
// Package: types, constants and tables for the wrapping dot intensity engine
`timescale 1ns / 1ps
`default_nettype none
package wdie_pkg;

    localparam int DEF_GRID_WIDTH  = 16;
    localparam int DEF_GRID_HEIGHT = 16;
    localparam int DEF_CORDIC_STEPS = 14;

    localparam logic [15:0] TRIG_GAIN = 16'd39797;

    localparam logic [2:0] REG_RADIUS_MIN   = 3'd0;
    localparam logic [2:0] REG_RADIUS_MAX   = 3'd1;
    localparam logic [2:0] REG_HEADING      = 3'd2;
    localparam logic [2:0] REG_SPEED        = 3'd3;
    localparam logic [2:0] REG_START_X      = 3'd4;
    localparam logic [2:0] REG_START_Y      = 3'd5;
    localparam logic [2:0] REG_START_RADIUS = 3'd6;
    localparam logic [2:0] REG_RADIUS_STEP  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CORDIC,
        ST_MULX,
        ST_MULY,
        ST_WRAP,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DONE
    } state_t;

    // atan(2^-i), full turn = 2^32
    function automatic logic [29:0] arc_tab(input logic [3:0] i);
        logic [29:0] r;
        begin
            case (i)
                4'd0:  r = 30'd536870912;
                4'd1:  r = 30'd316933406;
                4'd2:  r = 30'd167458907;
                4'd3:  r = 30'd85004756;
                4'd4:  r = 30'd42667331;
                4'd5:  r = 30'd21354465;
                4'd6:  r = 30'd10679838;
                4'd7:  r = 30'd5340245;
                4'd8:  r = 30'd2670163;
                4'd9:  r = 30'd1335087;
                4'd10: r = 30'd667544;
                4'd11: r = 30'd333772;
                4'd12: r = 30'd166886;
                4'd13: r = 30'd83443;
                4'd14: r = 30'd41722;
                default: r = 30'd20861;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/wdie_core.sv =====
// Sequencer and shared iterative datapath: divide, CORDIC, multiply, square root
`timescale 1ns / 1ps
`default_nettype none
module wdie_core #(
    parameter int GRID_WIDTH   = wdie_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT  = wdie_pkg::DEF_GRID_HEIGHT,
    parameter int CORDIC_STEPS = wdie_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    input  wire logic        hold,
    input  wire logic        mode,
    input  wire logic [15:0] frame_time,
    input  wire logic [15:0] query_x,
    input  wire logic [15:0] query_y,
    output logic             busy,
    output logic             done,
    output logic [8:0]       res_intensity,
    output logic [15:0]      res_x,
    output logic [15:0]      res_y,
    output logic [15:0]      res_radius
);
    import wdie_pkg::*;

    localparam logic signed [18:0] EDGE_W = 19'(GRID_WIDTH * 256);
    localparam logic signed [18:0] EDGE_H = 19'(GRID_HEIGHT * 256);
    localparam logic signed [18:0] HALF_W = 19'((GRID_WIDTH * 256) / 2);
    localparam logic signed [18:0] HALF_H = 19'((GRID_HEIGHT * 256) / 2);
    localparam logic [3:0] LAST_STEP = 4'(CORDIC_STEPS - 1);

    state_t state_reg, state_next;

    logic [15:0] radius_min_reg, radius_max_reg, heading_reg, speed_reg;
    logic [15:0] pos_x_reg, pos_y_reg, cur_radius_reg;
    logic signed [15:0] cur_step_reg;

    logic [4:0]  cnt_reg;
    logic        mode_reg;
    logic [15:0] ft_reg, qx_reg, qy_reg;
    // divider
    logic [23:0] quo_reg;
    logic [16:0] rem_reg;
    // cordic
    logic signed [18:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic        flip_reg;
    logic signed [35:0] prod_reg;
    // square root
    logic [40:0] acc_reg;
    logic [41:0] rv_reg, rres_reg, rbit_reg;

    logic [15:0] travel;
    assign travel = (quo_reg > 24'd65535) ? 16'hFFFF : quo_reg[15:0];

    logic signed [16:0] ha;
    logic signed [16:0] hfold;
    logic hflip;
    always_comb
    begin
        ha = {heading_reg[15], heading_reg};
        hflip = 1'b0;
        hfold = ha;
        if (ha > 17'sd16384)
        begin
            hfold = ha - 17'sd32768;
            hflip = 1'b1;
        end
        else if (ha < -17'sd16384)
        begin
            hfold = ha + 17'sd32768;
            hflip = 1'b1;
        end
    end

    logic [16:0] rem_sh;
    logic signed [18:0] sx, sy;
    logic signed [18:0] mul_a;
    logic signed [17:0] mv;
    logic signed [18:0] nx;
    logic signed [18:0] dl, dr, al, ar, edge_sel, half_sel, off;
    logic [15:0] dabs;
    logic [31:0] sqd;
    logic [15:0] pq, qq;
    logic signed [15:0] mag;
    logic signed [17:0] rsum;
    logic [41:0] rtry;
    logic signed [42:0] ptmp;

    always_comb
    begin
        rem_sh = {rem_reg[15:0], quo_reg[23]};
        sx = cx_reg >>> cnt_reg[3:0];
        sy = cy_reg >>> cnt_reg[3:0];
        mul_a = (state_reg == ST_MULX) ? cy_reg : cx_reg;
        mv = 18'((prod_reg + 36'sd32768) >>> 16);
        // wrap uses the axis under work
        nx = 19'(signed'({3'b0, ((state_reg == ST_MULY) ? pos_y_reg : pos_x_reg)}))
             + 19'(mv);
        pq = (state_reg == ST_SQX) ? pos_x_reg : pos_y_reg;
        qq = (state_reg == ST_SQX) ? qx_reg : qy_reg;
        edge_sel = (state_reg == ST_SQX) ? EDGE_W : EDGE_H;
        half_sel = (state_reg == ST_SQX) ? HALF_W : HALF_H;
        off = (signed'({3'b0, qq}) < half_sel) ? -edge_sel : edge_sel;
        dl = signed'({3'b0, pq}) - signed'({3'b0, qq});
        dr = dl + off;
        al = dl[18] ? -dl : dl;
        ar = dr[18] ? -dr : dr;
        dabs = (al < ar) ? al[15:0] : ar[15:0];
        sqd = {16'd0, dabs} * {16'd0, dabs};
        mag = (cur_step_reg == -16'sd32768) ? 16'sd32767 :
              (cur_step_reg[15] ? -cur_step_reg : cur_step_reg);
        rsum = 18'(signed'({2'b0, cur_radius_reg})) + 18'(cur_step_reg);
        rtry = rres_reg + rbit_reg;
        ptmp = 43'(signed'({1'b0, cur_radius_reg})) - 43'(signed'({1'b0, rres_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = mode ? ST_SQX : ST_DIV;
            ST_DIV:    if (cnt_reg == 5'd23) state_next = ST_CORDIC;
            ST_CORDIC: if (cnt_reg[3:0] == LAST_STEP) state_next = ST_MULX;
            ST_MULX:   if (cnt_reg[0]) state_next = ST_MULY;
            ST_MULY:   if (cnt_reg[0]) state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_DONE;
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_ROOT;
            ST_ROOT:   if (cnt_reg == 5'd20) state_next = ST_DONE;
            ST_DONE:   if (!hold) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_min_reg <= 16'd0;
            radius_max_reg <= 16'd512;
            heading_reg    <= 16'd0;
            speed_reg      <= 16'd256;
            pos_x_reg      <= 16'd0;
            pos_y_reg      <= 16'd0;
            cur_radius_reg <= 16'd256;
            cur_step_reg   <= 16'sd16;
            cnt_reg        <= 5'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_RADIUS_MIN:   radius_min_reg <= cfg_data;
                    REG_RADIUS_MAX:   radius_max_reg <= cfg_data;
                    REG_HEADING:      heading_reg    <= cfg_data;
                    REG_SPEED:        speed_reg      <= cfg_data;
                    REG_START_X:      pos_x_reg      <= cfg_data;
                    REG_START_Y:      pos_y_reg      <= cfg_data;
                    REG_START_RADIUS: cur_radius_reg <= cfg_data;
                    REG_RADIUS_STEP:  cur_step_reg   <= signed'(cfg_data);
                    default: ;
                endcase
            end
            if (state_reg != state_next)
                cnt_reg <= 5'd0;
            else
                cnt_reg <= cnt_reg + 5'd1;
            if (state_reg == ST_WRAP)
            begin
                if (rsum > signed'({2'b0, radius_max_reg}))
                begin
                    if (signed'({2'b0, radius_max_reg}) < signed'({2'b0, radius_min_reg}))
                    begin
                        cur_radius_reg <= radius_min_reg;
                        cur_step_reg <= mag;
                    end
                    else
                    begin
                        cur_radius_reg <= radius_max_reg;
                        cur_step_reg <= -mag;
                    end
                end
                else if (rsum < signed'({2'b0, radius_min_reg}))
                begin
                    cur_radius_reg <= radius_min_reg;
                    cur_step_reg <= mag;
                end
                else
                    cur_radius_reg <= rsum[15:0];
            end
            // position update: x at end of MULX, y at end of MULY
            if ((state_reg == ST_MULX || state_reg == ST_MULY) && cnt_reg[0])
            begin
                if (state_reg == ST_MULX)
                begin
                    if (nx > EDGE_W) pos_x_reg <= 16'd0;
                    else if (nx < 19'sd0) pos_x_reg <= EDGE_W[15:0];
                    else pos_x_reg <= nx[15:0];
                end
                else
                begin
                    if (nx > EDGE_H) pos_y_reg <= 16'd0;
                    else if (nx < 19'sd0) pos_y_reg <= EDGE_H[15:0];
                    else pos_y_reg <= nx[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mode_reg <= mode;
                ft_reg   <= frame_time;
                qx_reg   <= query_x;
                qy_reg   <= query_y;
                quo_reg  <= {speed_reg, 8'd0};
                rem_reg  <= 17'd0;
                cx_reg   <= 19'(signed'({1'b0, TRIG_GAIN}));
                cy_reg   <= 19'sd0;
                cz_reg   <= 34'(hfold) <<< 16;
                flip_reg <= hflip;
                acc_reg  <= 41'd0;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, ft_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, ft_reg};
                    quo_reg <= {quo_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[22:0], 1'b0};
                end
            end
            ST_CORDIC:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - 34'(arc_tab(cnt_reg[3:0]));
                end
                else
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + 34'(arc_tab(cnt_reg[3:0]));
                end
                if (cnt_reg[3:0] == LAST_STEP && flip_reg)
                begin
                    cx_reg <= -(cz_reg[33] ? cx_reg + sy : cx_reg - sy);
                    cy_reg <= -(cz_reg[33] ? cy_reg - sx : cy_reg + sx);
                end
            end
            ST_MULX, ST_MULY:
            begin
                if (!cnt_reg[0])
                    prod_reg <= 36'(mul_a) * 36'(signed'({1'b0, travel}));
            end
            ST_SQX, ST_SQY:
            begin
                acc_reg <= acc_reg + 41'(sqd);
                rv_reg   <= {1'b0, acc_reg + 41'(sqd)};
                rres_reg <= 42'd0;
                rbit_reg <= 42'd1 << 40;
            end
            ST_ROOT:
            begin
                if (rv_reg >= rtry)
                begin
                    rv_reg <= rv_reg - rtry;
                    rres_reg <= (rres_reg >> 1) + rbit_reg;
                end
                else
                    rres_reg <= rres_reg >> 1;
                rbit_reg <= rbit_reg >> 2;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE) && !hold;
    assign res_intensity = mode_reg ?
                           ((ptmp > 43'sd256) ? 9'd256 :
                            (ptmp < 43'sd0) ? 9'd0 : ptmp[8:0]) : 9'd0;
    assign res_x = pos_x_reg;
    assign res_y = pos_y_reg;
    assign res_radius = cur_radius_reg;
endmodule
`default_nettype wire

// ===== hdl/wrapping_dot_intensity_engine.sv =====
// Top level: handshake, output register and core of the dot intensity engine
// A tick runs 24 divide steps, CORDIC_STEPS rotation steps, the x and y multiply states,
// the radius update and finish; a query runs two squaring steps, 21 root steps and finish.
// The next item is taken only when the core has returned to idle (in_stall follows busy).
// A result waiting in the output register does not stall input; the core waits at its finish.
// Reset (rst_n low, asynchronous) restores control, config and dot registers only.
`timescale 1ns / 1ps
`default_nettype none
module wrapping_dot_intensity_engine #(
    parameter int GRID_WIDTH   = wdie_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT  = wdie_pkg::DEF_GRID_HEIGHT,
    parameter int CORDIC_STEPS = wdie_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [15:0] frame_time,
    input  wire logic [15:0] query_x,
    input  wire logic [15:0] query_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [8:0]       intensity,
    output logic [15:0]      dot_x,
    output logic [15:0]      dot_y,
    output logic [15:0]      dot_radius
);
    import wdie_pkg::*;

    logic busy, done, start, hold;
    logic [8:0]  r_int;
    logic [15:0] r_x, r_y, r_rad;
    logic out_valid_reg;

    // core waits in DONE while the output register is occupied and stalled
    assign hold = out_valid_reg && out_stall;
    assign in_stall = busy;
    assign start = in_valid && !in_stall;

    wdie_core #(
        .GRID_WIDTH(GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_core (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .start(start), .hold(hold), .mode(mode), .frame_time(frame_time),
        .query_x(query_x), .query_y(query_y),
        .busy(busy), .done(done),
        .res_intensity(r_int), .res_x(r_x), .res_y(r_y), .res_radius(r_rad)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            intensity  <= r_int;
            dot_x      <= r_x;
            dot_y      <= r_y;
            dot_radius <= r_rad;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the wrapping dot intensity engine: random and directed ticks and queries
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import wdie_pkg::*;

    localparam int GRID_W = 16;
    localparam int GRID_H = 16;
    localparam int TRIG_STEPS = 14;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        mode;
        logic [15:0] frame_time;
        logic [15:0] query_x;
        logic [15:0] query_y;
    } item_t;

    typedef struct packed {
        logic [8:0]  intensity;
        logic [15:0] dot_x;
        logic [15:0] dot_y;
        logic [15:0] dot_radius;
    } dot_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [15:0] frame_time = 16'd1;
    logic [15:0] query_x = '0;
    logic [15:0] query_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [8:0] intensity;
    logic [15:0] dot_x, dot_y, dot_radius;

    always #5 clk = ~clk;

    wrapping_dot_intensity_engine dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .frame_time(frame_time),
        .query_x(query_x), .query_y(query_y), .out_valid(out_valid), .out_stall(out_stall),
        .intensity(intensity), .dot_x(dot_x), .dot_y(dot_y), .dot_radius(dot_radius)
    );

    // predicted dot state and registers
    longint r_min, r_max, r_heading, r_speed;
    longint px, py, rad, rstep;

    item_t pending_items[$];
    dot_result_t expected_dots[$];
    int errors = 0;
    bit quiet = 1'b0;
    bit hold_input = 1'b0;

    function automatic longint fshift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint arc_angle(int i);
        longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861};
        return t[i];
    endfunction

    function automatic longint wrap_coord(longint p, longint mv, longint edge_pos);
        longint n;
        n = p + mv;
        if (n > edge_pos)
            n = 0;
        if (n < 0)
            n = edge_pos;
        return n & 16'hFFFF;
    endfunction

    function automatic longint torus_sq(longint p, longint q, longint edge_pos);
        longint off, dl, dr, al, ar, d;
        off = (q < edge_pos / 2) ? -edge_pos : edge_pos;
        dl = p - q;
        dr = dl + off;
        al = dl < 0 ? -dl : dl;
        ar = dr < 0 ? -dr : dr;
        d = (al < ar) ? dl : dr;
        return d * d;
    endfunction

    function automatic longint isqrt(longint v);
        longint res, b;
        res = 0;
        b = 64'd1 << 40;
        for (int i = 0; i < 21; i++) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    task automatic predict_dot(input item_t it);
        dot_result_t r;
        longint travel, a, x, y, z, dx, dy, nr, mag, sq, p;
        bit flip;
        r.intensity = '0;
        if (it.mode == 1'b0) begin
            travel = 65535;
            if (it.frame_time != 0) begin
                travel = (r_speed << 8) / it.frame_time;
                if (travel > 65535)
                    travel = 65535;
            end
            a = r_heading;
            flip = 1'b0;
            if (a >= 32768)
                a -= 65536;
            if (a > 16384) begin
                a -= 32768;
                flip = 1'b1;
            end
            else if (a < -16384) begin
                a += 32768;
                flip = 1'b1;
            end
            x = TRIG_GAIN;
            y = 0;
            z = a * 65536;
            for (int i = 0; i < TRIG_STEPS; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= arc_angle(i);
                end
                else begin
                    x += dx;
                    y -= dy;
                    z += arc_angle(i);
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            px = wrap_coord(px, fshift(y * travel + 32768, 16), GRID_W * 256);
            py = wrap_coord(py, fshift(x * travel + 32768, 16), GRID_H * 256);
            nr = rad + rstep;
            mag = rstep < 0 ? -rstep : rstep;
            if (mag > 32767)
                mag = 32767;
            if (nr > r_max) begin
                nr = r_max;
                rstep = -mag;
            end
            if (nr < r_min) begin
                nr = r_min;
                rstep = mag;
            end
            rad = nr & 16'hFFFF;
        end
        else begin
            sq = torus_sq(px, it.query_x, GRID_W * 256) + torus_sq(py, it.query_y, GRID_H * 256);
            p = rad - isqrt(sq);
            if (p > 256)
                p = 256;
            if (p < 0)
                p = 0;
            r.intensity = p[8:0];
        end
        r.dot_x = px[15:0];
        r.dot_y = py[15:0];
        r.dot_radius = rad[15:0];
        expected_dots.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS_MIN:   r_min = val;
            REG_RADIUS_MAX:   r_max = val;
            REG_HEADING:      r_heading = val;
            REG_SPEED:        r_speed = val;
            REG_START_X:      px = val;
            REG_START_Y:      py = val;
            REG_START_RADIUS: rad = val;
            REG_RADIUS_STEP:  rstep = $signed(val);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_dots.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic item_t rand_item(bit tick_bias);
        item_t it;
        it.mode = tick_bias ? ($urandom_range(0, 2) == 0) : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: it.frame_time = 16'($urandom_range(0, 3));
            1: it.frame_time = 16'($urandom_range(64, 1024));
            default: it.frame_time = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0) begin
            it.query_x = 16'($urandom_range(0, GRID_W * 256));
            it.query_y = 16'($urandom_range(0, GRID_H * 256));
        end
        else begin
            it.query_x = 16'($urandom);
            it.query_y = 16'($urandom);
        end
        return it;
    endfunction

    task automatic random_config();
        write_reg(REG_RADIUS_MIN,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400)));
        write_reg(REG_RADIUS_MAX,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(200, 900)));
        write_reg(REG_HEADING, 16'($urandom));
        write_reg(REG_SPEED, 16'($urandom));
        write_reg(REG_START_X,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096)));
        write_reg(REG_START_Y,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096)));
        write_reg(REG_START_RADIUS, 16'($urandom_range(0, 1024)));
        write_reg(REG_RADIUS_STEP,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200) - 100));
    endtask

    // driver
    int in_gap = 0;
    always @(posedge clk) begin
        if (in_valid && !in_stall)
            void'(pending_items.pop_front());
        if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall)) begin
            if (pending_items.size() > (in_valid && !in_stall ? 0 : 0) && !hold_input
                    && pending_items.size() != 0) begin
                if (!quiet && $urandom_range(0, 15) == 0) begin
                    in_gap <= $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else begin
                    in_valid <= 1'b1;
                    mode <= pending_items[0].mode;
                    frame_time <= pending_items[0].frame_time;
                    query_x <= pending_items[0].query_x;
                    query_y <= pending_items[0].query_y;
                    predict_dot(pending_items[0]);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    int out_gap = 0;
    int idle_cycles = 0;
    always @(posedge clk) begin
        dot_result_t e;
        if (out_valid && !out_stall) begin
            if (expected_dots.size() == 0) begin
                $error("unexpected result: intensity %0d dot_x %0d", intensity, dot_x);
                errors++;
            end
            else begin
                e = expected_dots.pop_front();
                if (intensity !== e.intensity) begin
                    $error("intensity: expected %0d actual %0d", e.intensity, intensity);
                    errors++;
                end
                if (dot_x !== e.dot_x) begin
                    $error("dot_x: expected %0d actual %0d", e.dot_x, dot_x);
                    errors++;
                end
                if (dot_y !== e.dot_y) begin
                    $error("dot_y: expected %0d actual %0d", e.dot_y, dot_y);
                    errors++;
                end
                if (dot_radius !== e.dot_radius) begin
                    $error("dot_radius: expected %0d actual %0d", e.dot_radius, dot_radius);
                    errors++;
                end
            end
        end
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 19) == 0) begin
            out_gap <= $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we
                || (pending_items.size() == 0 && expected_dots.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** wrapping_dot_intensity_engine: FAILED **");
            $finish;
        end
    end

    initial begin
        item_t it;
        r_min = 0; r_max = 512; r_heading = 0; r_speed = 256;
        px = 0; py = 0; rad = 256; rstep = 16;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset state, then extremes
        pending_items.push_back('{1'b0, 16'd256, 16'd0, 16'd0});
        pending_items.push_back('{1'b1, 16'd1, 16'd0, 16'd0});
        pending_items.push_back('{1'b0, 16'd0, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{1'b0, 16'hFFFF, 16'd2048, 16'd2048});
        pending_items.push_back('{1'b1, 16'd1, 16'd2048, 16'd2048});
        drain();
        write_reg(REG_RADIUS_MIN, 16'd300);
        write_reg(REG_RADIUS_MAX, 16'd100);
        write_reg(REG_HEADING, 16'd16384);
        write_reg(REG_SPEED, 16'hFFFF);
        write_reg(REG_START_X, 16'hFFFF);
        write_reg(REG_START_Y, 16'd4096);
        write_reg(REG_START_RADIUS, 16'hFFFF);
        write_reg(REG_RADIUS_STEP, 16'h8000);
        for (int i = 0; i < 6; i++)
            pending_items.push_back('{i[0], 16'd1, 16'd4095, 16'd0});
        drain();
        write_reg(REG_RADIUS_MIN, 16'd0);
        write_reg(REG_RADIUS_MAX, 16'hFFFF);
        write_reg(REG_HEADING, 16'd32768);
        write_reg(REG_SPEED, 16'd0);
        write_reg(REG_START_X, 16'd0);
        write_reg(REG_START_Y, 16'd0);
        write_reg(REG_RADIUS_STEP, 16'h7FFF);
        for (int i = 0; i < 6; i++)
            pending_items.push_back('{i[0], 16'd256, 16'd128, 16'd4000});
        drain();
        write_reg(REG_HEADING, 16'd49152);
        write_reg(REG_SPEED, 16'd300);
        for (int i = 0; i < 4; i++)
            pending_items.push_back('{i[0], 16'd256, 16'd4000, 16'd4096});
        drain();

        // random phases
        for (int ph = 0; ph < 17; ph++) begin
            random_config();
            if (ph == 16)
                quiet = 1'b1;
            for (int i = 0; i < 100; i++) begin
                it = rand_item(ph % 2);
                pending_items.push_back(it);
                if (ph == 3 && i == 50) begin
                    repeat (200) @(posedge clk);
                    hold_input = 1'b1;
                    while (expected_dots.size() != 0 || in_valid)
                        @(posedge clk);
                    hold_input = 1'b0;
                end
            end
            drain();
        end
        if (errors == 0)
            $display("** wrapping_dot_intensity_engine: PASSED **");
        else
            $display("** wrapping_dot_intensity_engine: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
